/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion shorthands used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assertion sampled on clk, switched off while rst is high
`define LFP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// assertion sampled on clk, also checked while rst is high
`define LFP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/lfp_pkg.sv */
// ----------------------------------------------------------------------------
// lfp_pkg
// types, constants and helper functions of the foothold planner
// ----------------------------------------------------------------------------
`default_nettype none

package lfp_pkg;

  localparam int FIELD_W   = 16;
  localparam int LEG_ID_W  = 3;
  localparam int OUT_W     = 24;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;

  localparam int NUM_LEGS_DEF      = 6;
  localparam int CORDIC_STAGES_DEF = 16;

  // pipeline depth in front of and behind the rotation cells
  localparam int FRONT_DEPTH = 6;
  localparam int BACK_DEPTH  = 2;

  localparam int XY_W     = 32;
  localparam int Z_W      = 28;
  localparam int T_W      = 29;
  localparam int HX_W     = 35;
  localparam int SAT_IN_W = 40;
  localparam int RECIP_W  = 22;

  localparam logic [CFG_W-1:0] CFG_TIME_RESET = 16'd2048;

  localparam logic signed [T_W-1:0]  PI_Q24      = 29'sd52707179;
  localparam logic signed [T_W-1:0]  TWO_PI_Q24  = 29'sd105414357;
  localparam logic signed [Z_W-1:0]  HALF_PI_Q24 = 28'sd26353589;
  localparam logic signed [XY_W-1:0] GAIN_Q30    = 32'sd652032874;
  // floor(2^48 / two pi in q24)
  localparam logic [RECIP_W-1:0]     RECIP_2PI   = 22'd2670176;

  typedef enum logic [1:0] {
    KIND_LOAD   = 2'd0,
    KIND_STANCE = 2'd1,
    KIND_SWING  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STANCE_TIME = 1'b0,
    CFG_SWING_TIME  = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    kind_e                      kind;
    logic [LEG_ID_W-1:0]        leg_id;
    logic signed [FIELD_W-1:0]  vel_x;
    logic signed [FIELD_W-1:0]  vel_y;
    logic signed [FIELD_W-1:0]  yaw_rate_goal;
    logic [FIELD_W-1:0]         swing_phase;
    logic signed [FIELD_W-1:0]  slope_x;
    logic signed [FIELD_W-1:0]  slope_y;
    logic [FIELD_W-1:0]         load_radius;
    logic signed [FIELD_W-1:0]  load_angle;
  } request_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] foot_x;
    logic signed [OUT_W-1:0] foot_y;
    logic signed [OUT_W-1:0] foot_z;
  } result_t;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } cordic_vec_t;

  typedef struct packed {
    logic                    neg;
    logic [FIELD_W-1:0]      radius;
    logic signed [HX_W-1:0]  hx;
    logic signed [HX_W-1:0]  hy;
    logic signed [OUT_W-1:0] foot_z;
  } cordic_tag_t;

  function automatic logic [23:0] atan_q24(input int unsigned idx);
    logic [23:0] a;
    case (idx)
      0:  a = 24'd13176795;
      1:  a = 24'd7778716;
      2:  a = 24'd4110060;
      3:  a = 24'd2086331;
      4:  a = 24'd1047214;
      5:  a = 24'd524117;
      6:  a = 24'd262123;
      7:  a = 24'd131069;
      8:  a = 24'd65536;
      9:  a = 24'd32768;
      10: a = 24'd16384;
      11: a = 24'd8192;
      12: a = 24'd4096;
      13: a = 24'd2048;
      14: a = 24'd1024;
      15: a = 24'd512;
      16: a = 24'd256;
      17: a = 24'd128;
      18: a = 24'd64;
      19: a = 24'd32;
      20: a = 24'd16;
      21: a = 24'd8;
      22: a = 24'd4;
      23: a = 24'd2;
      default: a = 24'd0;
    endcase
    return a;
  endfunction

  function automatic logic signed [OUT_W-1:0] sat24(input logic signed [SAT_IN_W-1:0] v);
    logic signed [OUT_W-1:0] r;
    if (v > 40'sd8388607) begin
      r = 24'sh7fffff;
    end else if (v < -40'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = v[OUT_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* design/lfp_front.sv */
// ----------------------------------------------------------------------------
// lfp_front
// leg tables, timing registers, step offset and angle reduction pipeline
// ----------------------------------------------------------------------------
`default_nettype none

module lfp_front #(
  parameter int NUM_LEGS = lfp_pkg::NUM_LEGS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  lfp_pkg::request_t             request,
  input  logic                          cfg_we,
  input  logic [lfp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lfp_pkg::CFG_W-1:0]     cfg_data,
  output logic                          valid_out,
  output lfp_pkg::cordic_vec_t          vec_out,
  output lfp_pkg::cordic_tag_t          tag_out
);
  import lfp_pkg::*;

  localparam int LEG_W = (NUM_LEGS > 1) ? $clog2(NUM_LEGS) : 1;
  localparam logic [LEG_ID_W:0] LEG_LIMIT = (LEG_ID_W + 1)'(NUM_LEGS);

  logic [CFG_W-1:0]   stance_time;
  logic [CFG_W-1:0]   swing_time;
  logic [FIELD_W-1:0] radius_table [NUM_LEGS];
  logic [FIELD_W-1:0] angle_table  [NUM_LEGS];

  logic [LEG_W-1:0] leg_idx;
  logic             leg_ok;
  logic             foothold;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      stance_time <= CFG_TIME_RESET;
      swing_time  <= CFG_TIME_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_STANCE_TIME: stance_time <= cfg_data;
        CFG_SWING_TIME:  swing_time  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign leg_idx  = request.leg_id[LEG_W-1:0];
  assign leg_ok   = {1'b0, request.leg_id} < LEG_LIMIT;
  assign foothold = accept && leg_ok &&
                    (request.kind == KIND_STANCE || request.kind == KIND_SWING);

  always_ff @(posedge clk) begin
    if (accept && leg_ok && request.kind == KIND_LOAD) begin
      radius_table[leg_idx] <= request.load_radius;
      angle_table[leg_idx]  <= request.load_angle;
    end
  end

  // stage 1: time products
  logic signed [32:0]  vts_x0, vts_y0, wts0;
  logic [16:0]         rem0;
  logic [32:0]         remtw0;

  assign vts_x0 = request.vel_x * $signed({1'b0, stance_time});
  assign vts_y0 = request.vel_y * $signed({1'b0, stance_time});
  assign wts0   = request.yaw_rate_goal * $signed({1'b0, stance_time});
  assign rem0   = 17'h10000 - {1'b0, request.swing_phase};
  assign remtw0 = rem0 * swing_time;

  logic                      r1_valid;
  logic                      r1_swing;
  logic signed [32:0]        r1_vts_x, r1_vts_y, r1_wts;
  logic [32:0]               r1_remtw;
  logic signed [FIELD_W-1:0] r1_vx, r1_vy, r1_sx, r1_sy, r1_angle;
  logic [FIELD_W-1:0]        r1_radius;

  always_ff @(posedge clk) begin
    if (rst) begin
      r1_valid <= 1'b0;
    end else begin
      r1_valid <= foothold;
    end
  end

  always_ff @(posedge clk) begin
    r1_swing  <= request.kind == KIND_SWING;
    r1_vts_x  <= vts_x0;
    r1_vts_y  <= vts_y0;
    r1_wts    <= wts0;
    r1_remtw  <= remtw0;
    r1_vx     <= request.vel_x;
    r1_vy     <= request.vel_y;
    r1_sx     <= request.slope_x;
    r1_sy     <= request.slope_y;
    r1_radius <= radius_table[leg_idx];
    r1_angle  <= angle_table[leg_idx];
  end

  // stage 2: swing products, yaw offset and angle sum
  logic signed [32:0] yaw2;
  logic signed [34:0] u2;
  logic signed [49:0] pxw2, pyw2;

  assign yaw2 = r1_swing ? (r1_wts >>> 1) : -r1_wts;
  assign u2   = $signed({r1_angle, 11'b0}) + yaw2 + PI_Q24;
  assign pxw2 = r1_vx * $signed({1'b0, r1_remtw});
  assign pyw2 = r1_vy * $signed({1'b0, r1_remtw});

  logic                      r2_valid;
  logic                      r2_swing;
  logic signed [49:0]        r2_pxw, r2_pyw;
  logic signed [32:0]        r2_vts_x, r2_vts_y;
  logic signed [34:0]        r2_u;
  logic signed [FIELD_W-1:0] r2_sx, r2_sy;
  logic [FIELD_W-1:0]        r2_radius;

  always_ff @(posedge clk) begin
    if (rst) begin
      r2_valid <= 1'b0;
    end else begin
      r2_valid <= r1_valid;
    end
  end

  always_ff @(posedge clk) begin
    r2_swing  <= r1_swing;
    r2_pxw    <= pxw2;
    r2_pyw    <= pyw2;
    r2_vts_x  <= r1_vts_x;
    r2_vts_y  <= r1_vts_y;
    r2_u      <= u2;
    r2_sx     <= r1_sx;
    r2_sy     <= r1_sy;
    r2_radius <= r1_radius;
  end

  // stage 3: step offset and turn count estimate
  logic signed [33:0]        pxs3, pys3;
  logic signed [31:0]        vhx3, vhy3;
  logic signed [HX_W-1:0]    hx3, hy3;
  logic signed [18:0]        uh3;
  logic signed [41:0]        qprod3;

  assign pxs3   = $signed(r2_pxw[49:16]);
  assign pys3   = $signed(r2_pyw[49:16]);
  assign vhx3   = $signed(r2_vts_x[32:1]);
  assign vhy3   = $signed(r2_vts_y[32:1]);
  assign hx3    = r2_swing ? (pxs3 + vhx3) : -r2_vts_x;
  assign hy3    = r2_swing ? (pys3 + vhy3) : -r2_vts_y;
  assign uh3    = $signed(r2_u[34:16]);
  assign qprod3 = uh3 * $signed({1'b0, RECIP_2PI});

  logic                      r3_valid;
  logic signed [HX_W-1:0]    r3_hx, r3_hy;
  logic signed [34:0]        r3_u;
  logic signed [9:0]         r3_q;
  logic signed [FIELD_W-1:0] r3_sx, r3_sy;
  logic [FIELD_W-1:0]        r3_radius;

  always_ff @(posedge clk) begin
    if (rst) begin
      r3_valid <= 1'b0;
    end else begin
      r3_valid <= r2_valid;
    end
  end

  always_ff @(posedge clk) begin
    r3_hx     <= hx3;
    r3_hy     <= hy3;
    r3_u      <= r2_u;
    r3_q      <= $signed(qprod3[41:32]);
    r3_sx     <= r2_sx;
    r3_sy     <= r2_sy;
    r3_radius <= r2_radius;
  end

  // stage 4: remainder and terrain products
  logic signed [37:0] t4;
  logic signed [50:0] psx4, psy4;

  assign t4   = r3_u - r3_q * TWO_PI_Q24;
  assign psx4 = r3_sx * r3_hx;
  assign psy4 = r3_sy * r3_hy;

  logic                   r4_valid;
  logic signed [T_W-1:0]  r4_t;
  logic signed [50:0]     r4_psx, r4_psy;
  logic signed [HX_W-1:0] r4_hx, r4_hy;
  logic [FIELD_W-1:0]     r4_radius;

  always_ff @(posedge clk) begin
    if (rst) begin
      r4_valid <= 1'b0;
    end else begin
      r4_valid <= r3_valid;
    end
  end

  always_ff @(posedge clk) begin
    r4_t      <= t4[T_W-1:0];
    r4_psx    <= psx4;
    r4_psy    <= psy4;
    r4_hx     <= r3_hx;
    r4_hy     <= r3_hy;
    r4_radius <= r3_radius;
  end

  // stage 5: remainder correction, centered angle, height
  logic signed [T_W-1:0] t5, z5;
  logic signed [51:0]    zsum5;
  logic signed [31:0]    zsh5;

  always_comb begin
    if (r4_t < 0) begin
      t5 = r4_t + TWO_PI_Q24;
    end else if (r4_t >= TWO_PI_Q24) begin
      t5 = r4_t - TWO_PI_Q24;
    end else begin
      t5 = r4_t;
    end
  end

  assign z5    = t5 - PI_Q24;
  assign zsum5 = r4_psx + r4_psy;
  assign zsh5  = $signed(zsum5[51:20]);

  logic                    r5_valid;
  logic signed [Z_W-1:0]   r5_z;
  logic signed [OUT_W-1:0] r5_foot_z;
  logic signed [HX_W-1:0]  r5_hx, r5_hy;
  logic [FIELD_W-1:0]      r5_radius;

  always_ff @(posedge clk) begin
    if (rst) begin
      r5_valid <= 1'b0;
    end else begin
      r5_valid <= r4_valid;
    end
  end

  always_ff @(posedge clk) begin
    r5_z      <= z5[Z_W-1:0];
    r5_foot_z <= sat24(SAT_IN_W'(zsh5));
    r5_hx     <= r4_hx;
    r5_hy     <= r4_hy;
    r5_radius <= r4_radius;
  end

  // stage 6: fold into the right half plane
  logic signed [Z_W-1:0] z6;
  logic                  neg6;

  always_comb begin
    z6   = r5_z;
    neg6 = 1'b0;
    if (r5_z > HALF_PI_Q24) begin
      z6   = Z_W'(r5_z - PI_Q24);
      neg6 = 1'b1;
    end else if (r5_z < -HALF_PI_Q24) begin
      z6   = Z_W'(r5_z + PI_Q24);
      neg6 = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= r5_valid;
    end
  end

  always_ff @(posedge clk) begin
    vec_out.x      <= GAIN_Q30;
    vec_out.y      <= '0;
    vec_out.z      <= z6;
    tag_out.neg    <= neg6;
    tag_out.radius <= r5_radius;
    tag_out.hx     <= r5_hx;
    tag_out.hy     <= r5_hy;
    tag_out.foot_z <= r5_foot_z;
  end

endmodule

`default_nettype wire

/* design/lfp_cordic_cell.sv */
// ----------------------------------------------------------------------------
// lfp_cordic_cell
// one rotation step of the sine and cosine chain
// ----------------------------------------------------------------------------
`default_nettype none

module lfp_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 valid_in,
  input  lfp_pkg::cordic_vec_t vec_in,
  input  lfp_pkg::cordic_tag_t tag_in,
  output logic                 valid_out,
  output lfp_pkg::cordic_vec_t vec_out,
  output lfp_pkg::cordic_tag_t tag_out
);
  import lfp_pkg::*;

  localparam logic signed [Z_W-1:0] ATAN_STEP = $signed(Z_W'(atan_q24(STAGE)));

  logic signed [XY_W-1:0] xs, ys;
  logic                   dir;
  cordic_vec_t            vec_next;

  assign xs  = vec_in.x >>> STAGE;
  assign ys  = vec_in.y >>> STAGE;
  assign dir = !vec_in.z[Z_W-1];

  always_comb begin
    if (dir) begin
      vec_next.x = vec_in.x - ys;
      vec_next.y = vec_in.y + xs;
      vec_next.z = vec_in.z - ATAN_STEP;
    end else begin
      vec_next.x = vec_in.x + ys;
      vec_next.y = vec_in.y - xs;
      vec_next.z = vec_in.z + ATAN_STEP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    vec_out <= vec_next;
    tag_out <= tag_in;
  end

endmodule

`default_nettype wire

/* design/lfp_back.sv */
// ----------------------------------------------------------------------------
// lfp_back
// scales the rotated leg radius, adds the step offset and saturates
// ----------------------------------------------------------------------------
`default_nettype none

module lfp_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 valid_in,
  input  lfp_pkg::cordic_vec_t vec_in,
  input  lfp_pkg::cordic_tag_t tag_in,
  output logic                 done,
  output lfp_pkg::result_t     result
);
  import lfp_pkg::*;

  logic signed [XY_W:0] c1, s1;
  logic signed [49:0]   prx1, pry1;

  assign c1   = tag_in.neg ? -(XY_W + 1)'(vec_in.x) : (XY_W + 1)'(vec_in.x);
  assign s1   = tag_in.neg ? -(XY_W + 1)'(vec_in.y) : (XY_W + 1)'(vec_in.y);
  assign prx1 = $signed({1'b0, tag_in.radius}) * c1;
  assign pry1 = $signed({1'b0, tag_in.radius}) * s1;

  logic                    b1_valid;
  logic signed [49:0]      b1_prx, b1_pry;
  logic signed [HX_W-1:0]  b1_hx, b1_hy;
  logic signed [OUT_W-1:0] b1_foot_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid <= 1'b0;
    end else begin
      b1_valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    b1_prx    <= prx1;
    b1_pry    <= pry1;
    b1_hx     <= tag_in.hx;
    b1_hy     <= tag_in.hy;
    b1_foot_z <= tag_in.foot_z;
  end

  logic signed [29:0]   rx2, ry2;
  logic signed [HX_W:0] sx2, sy2;
  logic signed [27:0]   fx2, fy2;

  assign rx2 = $signed(b1_prx[49:20]);
  assign ry2 = $signed(b1_pry[49:20]);
  assign sx2 = b1_hx + rx2;
  assign sy2 = b1_hy + ry2;
  assign fx2 = $signed(sx2[HX_W:8]);
  assign fy2 = $signed(sy2[HX_W:8]);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= b1_valid;
    end
  end

  always_ff @(posedge clk) begin
    result.foot_x <= sat24(SAT_IN_W'(fx2));
    result.foot_y <= sat24(SAT_IN_W'(fy2));
    result.foot_z <= b1_foot_z;
  end

endmodule

`default_nettype wire

/* design/legged_foothold_planner_core.sv */
// ----------------------------------------------------------------------------
// legged_foothold_planner_core
// foothold planner: step offset from goal velocity, leg radius rotated by
// the leg angle plus yaw offset, height from the terrain plane
// ----------------------------------------------------------------------------
// usage
//   request: start with the request struct; taken at any edge with start
//   high and busy low. busy stays low, so one request per cycle is taken.
//   kind load writes the leg's radius and angle and gives no result; a
//   stance or swing request to a loaded leg gives one result, out of range
//   legs and the unknown kind give none.
//   result: done high for one cycle with the result struct, after six
//   front stages, one rotation cell per stage and two output stages.
//   the receiver takes every result, there is no stall.
//   configuration: cfg_we with cfg_index and cfg_data writes stance_time or
//   swing_time; users write only while no request is in flight, unchecked.
//   reset: clears all pipeline valids and sets both times to 2048; the leg
//   tables hold no defined value until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module legged_foothold_planner_core #(
  parameter int NUM_LEGS      = lfp_pkg::NUM_LEGS_DEF,
  parameter int CORDIC_STAGES = lfp_pkg::CORDIC_STAGES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  lfp_pkg::request_t             request,
  output logic                          done,
  output lfp_pkg::result_t              result,
  input  logic                          cfg_we,
  input  logic [lfp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lfp_pkg::CFG_W-1:0]     cfg_data
);
  import lfp_pkg::*;

  logic        valid_chain [CORDIC_STAGES + 1];
  cordic_vec_t vec_chain   [CORDIC_STAGES + 1];
  cordic_tag_t tag_chain   [CORDIC_STAGES + 1];
  logic        accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  lfp_front #(
    .NUM_LEGS (NUM_LEGS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .request   (request),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .valid_out (valid_chain[0]),
    .vec_out   (vec_chain[0]),
    .tag_out   (tag_chain[0])
  );

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    lfp_cordic_cell #(
      .STAGE (g)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .valid_in  (valid_chain[g]),
      .vec_in    (vec_chain[g]),
      .tag_in    (tag_chain[g]),
      .valid_out (valid_chain[g + 1]),
      .vec_out   (vec_chain[g + 1]),
      .tag_out   (tag_chain[g + 1])
    );
  end

  lfp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .valid_in (valid_chain[CORDIC_STAGES]),
    .vec_in   (vec_chain[CORDIC_STAGES]),
    .tag_in   (tag_chain[CORDIC_STAGES]),
    .done     (done),
    .result   (result)
  );

endmodule

`default_nettype wire

/* design/lfp_checker.sv */
// ----------------------------------------------------------------------------
// lfp_checker
// port level checks of request to result timing of the planner
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module lfp_checker #(
  parameter int NUM_LEGS      = lfp_pkg::NUM_LEGS_DEF,
  parameter int CORDIC_STAGES = lfp_pkg::CORDIC_STAGES_DEF
) (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input lfp_pkg::request_t request,
  input logic              done
);
  import lfp_pkg::*;

  localparam int LATENCY = FRONT_DEPTH + CORDIC_STAGES + BACK_DEPTH;
  localparam logic [LEG_ID_W:0] LEG_LIMIT = (LEG_ID_W + 1)'(NUM_LEGS);

  logic accept;
  logic foothold_req;
  logic other_req;

  assign accept       = start && !busy;
  assign foothold_req = accept && ({1'b0, request.leg_id} < LEG_LIMIT) &&
                        (request.kind == KIND_STANCE || request.kind == KIND_SWING);
  assign other_req    = !foothold_req;

  `LFP_ASSERT(a_foothold_done, foothold_req |-> ##LATENCY done, "missing result")
  `LFP_ASSERT(a_no_spurious_done, other_req |-> ##LATENCY !done, "result without request")
  `LFP_ASSERT_ALWAYS(a_reset_quiet, rst |=> !done, "result right after reset")

endmodule

bind legged_foothold_planner_core lfp_checker #(
  .NUM_LEGS      (NUM_LEGS),
  .CORDIC_STAGES (CORDIC_STAGES)
) u_lfp_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .request (request),
  .done    (done)
);

`default_nettype wire

/* test/legged_foothold_planner_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// legged_foothold_planner_core_tb
// Self-checking bench for the foothold planner. It loads the six legs' radius
// and angle, then sends a directed set of stance, swing, ignored and
// out-of-range requests, then random batches under several stance and swing
// times with the sender idling at different rates. Each accepted request runs
// through a bit-accurate planner (step offset, angle wrap, rotation stages,
// saturation) kept in the bench, and every strobed result is compared field
// by field with the oldest expected foothold.
// ----------------------------------------------------------------------------

module legged_foothold_planner_core_tb;
  import lfp_pkg::*;

  localparam int LEGS        = NUM_LEGS_DEF;
  localparam int STAGES      = CORDIC_STAGES_DEF;
  localparam int LATENCY     = FRONT_DEPTH + STAGES + BACK_DEPTH;
  localparam int DRAIN_LIMIT = 20 * LATENCY;
  localparam int BATCHES     = 9;
  localparam int BATCH_SIZE  = 180;

  localparam longint PI_24      = 52707179;
  localparam longint TWO_PI_24  = 105414357;
  localparam longint HALF_PI_24 = 26353589;
  localparam longint GAIN_30    = 652032874;

  localparam longint ATAN_24 [16] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512
  };

  // negative entries pick a random time
  localparam int STANCE_SET [BATCHES] = '{0, 65535, -1, 4096, 65535, -1, 0, -1, 1};
  localparam int SWING_SET  [BATCHES] = '{65535, 0, -1, -1, 65535, 0, 0, -1, 4096};

  logic                 clk;
  logic                 rst       = 1'b1;
  logic                 start     = 1'b0;
  logic                 busy;
  request_t             req       = '0;
  logic                 done;
  result_t              res;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;

  request_t pending_q[$];
  result_t  foothold_q[$];
  int       sender_idle = 0;
  int       errors      = 0;

  logic [15:0]        stance_time = 16'd2048;
  logic [15:0]        swing_time  = 16'd2048;
  logic [15:0]        leg_radius [LEGS];
  logic signed [15:0] leg_angle  [LEGS];

  legged_foothold_planner_core #(
    .NUM_LEGS     (LEGS),
    .CORDIC_STAGES(STAGES)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .request  (req),
    .done     (done),
    .result   (res),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic signed [23:0] clamp24(input longint v);
    if (v > 8388607) return 24'sh7fffff;
    if (v < -8388608) return 24'sh800000;
    return v[23:0];
  endfunction

  function automatic bit plan_foothold(input request_t rq, output result_t foot);
    longint vx, vy, w, sx, sy, ts, tw, hx, hy, yaw, z, x, y, xs, ys, rad;
    bit flip;
    foot = '0;
    if (rq.leg_id >= LEGS || rq.kind == KIND_NONE) return 1'b0;
    if (rq.kind == KIND_LOAD) begin
      leg_radius[rq.leg_id] = rq.load_radius;
      leg_angle[rq.leg_id]  = rq.load_angle;
      return 1'b0;
    end
    vx = $signed(rq.vel_x);
    vy = $signed(rq.vel_y);
    w  = $signed(rq.yaw_rate_goal);
    sx = $signed(rq.slope_x);
    sy = $signed(rq.slope_y);
    ts = stance_time;
    tw = swing_time;
    if (rq.kind == KIND_STANCE) begin
      hx  = -(vx * ts);
      hy  = -(vy * ts);
      yaw = -(w * ts);
    end else begin
      hx  = ((vx * (65536 - longint'(rq.swing_phase)) * tw) >>> 16) + ((vx * ts) >>> 1);
      hy  = ((vy * (65536 - longint'(rq.swing_phase)) * tw) >>> 16) + ((vy * ts) >>> 1);
      yaw = (w * ts) >>> 1;
    end
    // wrap into [-pi, pi), then fold into the right half plane
    z = (longint'(leg_angle[rq.leg_id]) * 2048 + yaw + PI_24) % TWO_PI_24;
    if (z < 0) z += TWO_PI_24;
    z -= PI_24;
    flip = 1'b0;
    if (z > HALF_PI_24) begin
      z -= PI_24;
      flip = 1'b1;
    end else if (z < -HALF_PI_24) begin
      z += PI_24;
      flip = 1'b1;
    end
    x = GAIN_30;
    y = 0;
    for (int i = 0; i < STAGES; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys;
        y += xs;
        z -= ATAN_24[i];
      end else begin
        x += ys;
        y -= xs;
        z += ATAN_24[i];
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    rad = leg_radius[rq.leg_id];
    foot.foot_x = clamp24((hx + ((rad * x) >>> 20)) >>> 8);
    foot.foot_y = clamp24((hy + ((rad * y) >>> 20)) >>> 8);
    foot.foot_z = clamp24((sx * hx + sy * hy) >>> 20);
    return 1'b1;
  endfunction

  function automatic request_t mk_req(input kind_e k, input int leg, input int vx,
                                      input int vy, input int w, input int ph,
                                      input int sx, input int sy, input int rad,
                                      input int ang);
    request_t rq;
    rq.kind          = k;
    rq.leg_id        = leg[2:0];
    rq.vel_x         = vx[15:0];
    rq.vel_y         = vy[15:0];
    rq.yaw_rate_goal = w[15:0];
    rq.swing_phase   = ph[15:0];
    rq.slope_x       = sx[15:0];
    rq.slope_y       = sy[15:0];
    rq.load_radius   = rad[15:0];
    rq.load_angle    = ang[15:0];
    return rq;
  endfunction

  function automatic int pick_field();
    case ($urandom_range(9))
      0, 1, 2, 3: return int'($urandom_range(65535)) - 32768;
      4, 5, 6, 7: return int'($urandom_range(4096)) - 2048;
      8:          return $urandom_range(1) ? 32767 : -32768;
      default:    return 0;
    endcase
  endfunction

  function automatic request_t random_request();
    int    pick;
    int    leg;
    int    ph;
    kind_e k;
    pick = $urandom_range(99);
    leg  = $urandom_range(LEGS - 1);
    k    = $urandom_range(1) ? KIND_SWING : KIND_STANCE;
    ph   = ($urandom_range(19) == 0) ? ($urandom_range(1) ? 65535 : 0) : $urandom_range(65535);
    if (pick < 10) begin
      k   = KIND_LOAD;
      leg = $urandom_range(7);
    end else if (pick < 13) begin
      k   = KIND_NONE;
      leg = $urandom_range(7);
    end else if (pick < 17) begin
      leg = $urandom_range(7, LEGS);
    end
    return mk_req(k, leg, pick_field(), pick_field(), pick_field(), ph, pick_field(),
                  pick_field(), $urandom_range(65535), $urandom_range(65535));
  endfunction

  task automatic flag_error(input string msg);
    errors++;
    if (errors <= 10) $display("mismatch: %s", msg);
  endtask

  task automatic check_field(input string name, input logic signed [23:0] want,
                             input logic signed [23:0] got);
    if (got !== want) flag_error($sformatf("%s expected %0d got %0d", name, want, got));
  endtask

  task automatic write_config(input int st, input int sw);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_STANCE_TIME;
    cfg_data  <= st[15:0];
    @(posedge clk);
    cfg_index <= CFG_SWING_TIME;
    cfg_data  <= sw[15:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  task automatic settle();
    int guard;
    guard = 0;
    @(negedge clk);
    while (pending_q.size() != 0 || start) @(negedge clk);
    while (foothold_q.size() != 0 && guard < DRAIN_LIMIT) begin
      @(negedge clk);
      guard++;
    end
    if (foothold_q.size() != 0) begin
      flag_error($sformatf("%0d footholds never arrived", foothold_q.size()));
      foothold_q.delete();
    end
    repeat (LATENCY + 8) @(negedge clk);
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (pending_q.size() != 0 && $urandom_range(99) >= sender_idle) begin
        start <= 1'b1;
        req   <= pending_q.pop_front();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // result monitor and planner
  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (rst) begin
      stance_time = 16'd2048;
      swing_time  = 16'd2048;
    end else begin
      if (done) begin
        got = res;
        if (foothold_q.size() == 0) begin
          flag_error($sformatf("unexpected foothold x=%0d y=%0d z=%0d",
                               got.foot_x, got.foot_y, got.foot_z));
        end else begin
          want = foothold_q.pop_front();
          check_field("foot_x", want.foot_x, got.foot_x);
          check_field("foot_y", want.foot_y, got.foot_y);
          check_field("foot_z", want.foot_z, got.foot_z);
        end
      end
      if (start && !busy) begin
        if (plan_foothold(req, want)) foothold_q.push_back(want);
      end
      if (cfg_we) begin
        case (cfg_reg_e'(cfg_index))
          CFG_STANCE_TIME: stance_time = cfg_data;
          CFG_SWING_TIME:  swing_time  = cfg_data;
          default: ;
        endcase
      end
    end
  end

  initial begin
    request_t rq;
    int       kept;
    int       st;
    int       sw;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // leg geometry, including ignored loads to legs 6 and 7
    pending_q.push_back(mk_req(KIND_LOAD, 0, 0, 0, 0, 0, 0, 0, 16384, 0));
    pending_q.push_back(mk_req(KIND_LOAD, 1, 0, 0, 0, 0, 0, 0, 65535, 32767));
    pending_q.push_back(mk_req(KIND_LOAD, 2, 0, 0, 0, 0, 0, 0, 0, -32768));
    pending_q.push_back(mk_req(KIND_LOAD, 3, 0, 0, 0, 0, 0, 0, 8192, 12868));
    pending_q.push_back(mk_req(KIND_LOAD, 4, 0, 0, 0, 0, 0, 0, 30000, -12868));
    pending_q.push_back(mk_req(KIND_LOAD, 5, 0, 0, 0, 0, 0, 0, 20000, 25736));
    pending_q.push_back(mk_req(KIND_LOAD, 6, 0, 0, 0, 0, 0, 0, 1, 1));
    pending_q.push_back(mk_req(KIND_LOAD, 7, 0, 0, 0, 0, 0, 0, 65535, -1));
    // footholds at the field extremes
    pending_q.push_back(mk_req(KIND_STANCE, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(mk_req(KIND_STANCE, 1, 32767, -32768, 32767, 0, 32767, -32768,
                               0, 0));
    pending_q.push_back(mk_req(KIND_STANCE, 2, -32768, 32767, -32768, 0, -32768, 32767,
                               0, 0));
    pending_q.push_back(mk_req(KIND_SWING, 3, 4096, -4096, 8192, 0, 1024, -1024, 0, 0));
    pending_q.push_back(mk_req(KIND_SWING, 4, -32768, 32767, 32767, 65535, 32767, 32767,
                               0, 0));
    pending_q.push_back(mk_req(KIND_SWING, 5, 32767, 32767, -32768, 32768, -32768, -32768,
                               0, 0));
    // no result: legs out of range, unknown kind
    pending_q.push_back(mk_req(KIND_STANCE, 6, 100, 100, 100, 0, 100, 100, 0, 0));
    pending_q.push_back(mk_req(KIND_SWING, 7, -100, 100, 5, 1000, 7, 9, 0, 0));
    pending_q.push_back(mk_req(KIND_NONE, 0, 1234, -1234, 77, 4000, 88, 99, 555, 666));
    // reload a leg and use it right away
    pending_q.push_back(mk_req(KIND_LOAD, 2, 0, 0, 0, 0, 0, 0, 40000, 6434));
    pending_q.push_back(mk_req(KIND_SWING, 2, 1000, 2000, -3000, 16384, 500, -700, 0, 0));
    pending_q.push_back(mk_req(KIND_STANCE, 5, 0, 0, 32767, 0, 0, 0, 0, 0));
    pending_q.push_back(mk_req(KIND_SWING, 1, 32767, 32767, 32767, 0, 32767, 32767, 0, 0));
    pending_q.push_back(mk_req(KIND_STANCE, 3, -1, -1, -1, 0, -1, -1, 0, 0));
    pending_q.push_back(mk_req(KIND_SWING, 0, 1, -1, 1, 1, 1, 1, 0, 0));
    settle();

    for (int b = 0; b < BATCHES; b++) begin
      st = (STANCE_SET[b] < 0) ? $urandom_range(65535) : STANCE_SET[b];
      sw = (SWING_SET[b] < 0) ? $urandom_range(65535) : SWING_SET[b];
      write_config(st, sw);
      sender_idle = (b < 3) ? 37 : ((b < 6) ? 49 : 0);
      kept = 0;
      while (kept < BATCH_SIZE) begin
        rq = random_request();
        pending_q.push_back(rq);
        if (rq.kind != KIND_NONE && rq.leg_id < LEGS) kept++;
      end
      settle();
    end

    if (errors == 0) begin
      $display("[legged_foothold_planner_core] OK");
    end else begin
      $display("[legged_foothold_planner_core] ERROR");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("[legged_foothold_planner_core] ERROR");
    $finish;
  end

endmodule
